// ===== sv/tdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter package
// Shared widths, fixed-point constants and configuration register indexes.
// ----------------------------------------------------------------------------
package tdc_pkg;

  // Field and register widths.
  localparam int MV_W      = 12;
  localparam int OHM_W     = 20;
  localparam int COEF_W    = 48;
  localparam int TEMP_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 48;

  // Resistance quotient, unsigned Q32.16, and its leading-one position.
  localparam int Q_W = 48;
  localparam int P_W = 6;

  // Log datapath: mantissa Q1.30, fraction Q0.26, magnitudes of ln R powers.
  localparam int M_W       = 31;
  localparam int F_W       = 26;
  localparam int L_W       = 31;
  localparam int L2_W      = 35;
  localparam int L3_W      = 40;
  localparam int TB_W      = 53;
  localparam int TC_W      = 62;
  localparam int SUM_W     = 63;
  localparam int D_W       = 64;
  localparam int KC_W      = 16;

  localparam logic [29:0]     LN2_Q30      = 30'd744261118;
  localparam logic [KC_W-1:0] KC_MAX       = 16'd60082;
  localparam logic [KC_W-1:0] OFFSET_CENTI = 16'd27315;
  localparam logic [TEMP_W-1:0] TEMP_SAT   = 16'h7FFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERIES_OHMS = 3'd0,
    CFG_SUPPLY_MV   = 3'd1,
    CFG_COEF_A      = 3'd2,
    CFG_COEF_B      = 3'd3,
    CFG_COEF_C      = 3'd4
  } cfg_index_t;

endpackage

// ===== sv/tdc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter input channel
// Valid/ready channel that carries one divider voltage sample.
// ----------------------------------------------------------------------------
interface tdc_in_if import tdc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] divider_mv;

  modport source (output valid, output divider_mv, input ready);
  modport sink (input valid, input divider_mv, output ready);
endinterface

// ===== sv/tdc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter output channel
// Valid/ready channel that carries one temperature result.
// ----------------------------------------------------------------------------
interface tdc_out_if import tdc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_centi_c;
  logic                     valid_res;

  modport source (output valid, output temp_centi_c, output valid_res, input ready);
  modport sink (input valid, input temp_centi_c, input valid_res, output ready);
endinterface

// ===== sv/thermistor_divider_to_celsius.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor divider to Celsius converter
// Divider voltage to temperature through R, ln R and Steinhart-Hart.
// ----------------------------------------------------------------------------
// Usage:
// - in_ch carries one divider voltage in mV per transaction; out_ch returns
//   one temperature in 0.01 C per transaction, with valid_res low (and a
//   zero temperature) for a zero voltage, a voltage at or above the supply,
//   a zero series resistor or a nonpositive Steinhart-Hart denominator.
// - The configuration port writes one register per cycle while cfg_we is
//   high; write it only while no transaction is in flight.
// - The datapath is a 108-stage pipeline: a 48-stage radix-2 divider for R,
//   a 6-stage normalizer, 26 squaring stages for log2, the polynomial
//   stages and a 16-stage divider for Kelvin. One transaction can be
//   accepted every cycle while the receiver does not stall.
// - Reset clears the stage valid bits and loads the default configuration.
// - When the receiver stalls, the whole pipeline holds and in_ch.ready
//   drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module thermistor_divider_to_celsius import tdc_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  tdc_in_if.sink               in_ch,
  tdc_out_if.source            out_ch
);

  localparam logic [D_W-1:0] KELVIN_SCALE = 64'd100 << COEF_FRAC_BITS;

  // Stage positions in the valid chain.
  localparam int NM_STEPS = P_W;
  localparam int KD_STEPS = KC_W;
  localparam int ST_NM    = Q_W + NM_STEPS;
  localparam int ST_LG    = ST_NM + F_W;
  localparam int ST_KD    = ST_LG + 10 + KD_STEPS;
  localparam int DEPTH    = ST_KD + 2;

  // Configuration registers.
  logic [OHM_W-1:0]  series_ohms;
  logic [MV_W-1:0]   supply_mv;
  logic [COEF_W-1:0] coef_a;
  logic [COEF_W-1:0] coef_b;
  logic [COEF_W-1:0] coef_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_ohms <= 20'd100000;
      supply_mv   <= 12'd3300;
      coef_a      <= 48'd595316900000;
      coef_b      <= 48'd10787190000;
      coef_c      <= 48'd147157000;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SERIES_OHMS: series_ohms <= cfg_data[OHM_W-1:0];
        CFG_SUPPLY_MV:   supply_mv   <= cfg_data[MV_W-1:0];
        CFG_COEF_A:      coef_a      <= cfg_data[COEF_W-1:0];
        CFG_COEF_B:      coef_b      <= cfg_data[COEF_W-1:0];
        CFG_COEF_C:      coef_c      <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves when the output register can empty.
  logic             en;
  logic [DEPTH-1:0] vld;

  assign en          = !vld[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_ch.valid};
    end
  end

  // Entry stage and radix-2 divider for q = (series * (supply - v)) << 16 / v.
  logic [Q_W-1:0]  dv_num [0:Q_W];
  logic [MV_W-1:0] dv_rem [0:Q_W];
  logic [Q_W-1:0]  dv_quo [0:Q_W];
  logic [MV_W-1:0] dv_v   [0:Q_W];
  logic            dv_ok  [0:Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_num[0] <= {32'(series_ohms) * 32'(supply_mv - in_ch.divider_mv), 16'b0};
      dv_rem[0] <= '0;
      dv_quo[0] <= '0;
      dv_v[0]   <= in_ch.divider_mv;
      dv_ok[0]  <= (in_ch.divider_mv != '0) && (in_ch.divider_mv < supply_mv) &&
                   (series_ohms != '0);
    end
  end

  for (genvar i = 1; i <= Q_W; i++) begin : g_div
    logic [MV_W:0] trial;
    logic          fits;

    assign trial = {dv_rem[i-1], dv_num[i-1][Q_W-1]};
    assign fits  = trial >= {1'b0, dv_v[i-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        dv_num[i] <= dv_num[i-1] << 1;
        dv_rem[i] <= fits ? MV_W'(trial - {1'b0, dv_v[i-1]}) : trial[MV_W-1:0];
        dv_quo[i] <= {dv_quo[i-1][Q_W-2:0], fits};
        dv_v[i]   <= dv_v[i-1];
        dv_ok[i]  <= dv_ok[i-1];
      end
    end
  end

  // Normalizer: shift q left until its top bit is set, 32/16/8/4/2/1 per stage.
  logic [Q_W-1:0] nm_q  [0:NM_STEPS];
  logic [P_W-1:0] nm_s  [0:NM_STEPS];
  logic           nm_ok [0:NM_STEPS];

  assign nm_q[0]  = dv_quo[Q_W];
  assign nm_s[0]  = '0;
  assign nm_ok[0] = dv_ok[Q_W];

  for (genvar j = 1; j <= NM_STEPS; j++) begin : g_norm
    localparam int SH = 1 << (NM_STEPS - j);
    logic zero_top;

    assign zero_top = nm_q[j-1][Q_W-1 -: SH] == '0;

    always_ff @(posedge clk) begin
      if (en) begin
        nm_q[j]  <= zero_top ? (nm_q[j-1] << SH) : nm_q[j-1];
        nm_s[j]  <= nm_s[j-1] | (zero_top ? P_W'(SH) : '0);
        nm_ok[j] <= nm_ok[j-1];
      end
    end
  end

  // Log2 fraction: one squaring of the Q1.30 mantissa per stage.
  logic [M_W-1:0] lg_m  [0:F_W];
  logic [F_W-1:0] lg_f  [0:F_W];
  logic [P_W-1:0] lg_p  [0:F_W];
  logic           lg_ok [0:F_W];

  assign lg_m[0]  = nm_q[NM_STEPS][Q_W-1 -: M_W];
  assign lg_f[0]  = '0;
  assign lg_p[0]  = P_W'(Q_W - 1) - nm_s[NM_STEPS];
  assign lg_ok[0] = nm_ok[NM_STEPS];

  for (genvar k = 1; k <= F_W; k++) begin : g_log
    logic [2*M_W-1:0] sq;

    assign sq = lg_m[k-1] * lg_m[k-1];

    always_ff @(posedge clk) begin
      if (en) begin
        lg_m[k]  <= sq[2*M_W-1] ? sq[2*M_W-1:M_W] : sq[2*M_W-2:M_W-1];
        lg_f[k]  <= {lg_f[k-1][F_W-2:0], sq[2*M_W-1]};
        lg_p[k]  <= lg_p[k-1];
        lg_ok[k] <= lg_ok[k-1];
      end
    end
  end

  // Magnitude of log2 R in Q5.26 with its sign.
  logic [L_W-1:0] mg_mag;
  logic           mg_neg;
  logic           mg_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      if (lg_p[F_W] >= P_W'(16)) begin
        mg_mag <= {5'(lg_p[F_W] - P_W'(16)), lg_f[F_W]};
        mg_neg <= 1'b0;
      end else begin
        mg_mag <= {5'(P_W'(16) - lg_p[F_W]), 26'b0} - L_W'(lg_f[F_W]);
        mg_neg <= 1'b1;
      end
      mg_ok <= lg_ok[F_W];
    end
  end

  // ln R magnitude in Q5.26, rounded to nearest.
  logic [60:0]    ln_prod;
  logic [L_W-1:0] ln_l;
  logic           ln_neg;
  logic           ln_ok;

  assign ln_prod = 61'(mg_mag) * 61'(LN2_Q30) + 61'(1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      ln_l   <= ln_prod[60:30];
      ln_neg <= mg_neg;
      ln_ok  <= mg_ok;
    end
  end

  // Polynomial stage 1: L^2 and the two halves of coef_b * L.
  logic [61:0]    p1_sq;
  logic [54:0]    p1_tb0;
  logic [54:0]    p1_tb1;
  logic [L_W-1:0] p1_l;
  logic           p1_neg;
  logic           p1_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_sq  <= 62'(ln_l) * 62'(ln_l);
      p1_tb0 <= 55'(coef_b[23:0]) * 55'(ln_l);
      p1_tb1 <= 55'(coef_b[47:24]) * 55'(ln_l);
      p1_l   <= ln_l;
      p1_neg <= ln_neg;
      p1_ok  <= ln_ok;
    end
  end

  // Polynomial stage 2: partial products of L2 * L and the sum for tb.
  logic [78:0]     p2_tbfull;
  logic [48:0]     p2_l3a;
  logic [47:0]     p2_l3b;
  logic [TB_W-1:0] p2_tb;
  logic            p2_neg;
  logic            p2_ok;

  assign p2_tbfull = {p1_tb1, 24'b0} + 79'(p1_tb0);

  always_ff @(posedge clk) begin
    if (en) begin
      p2_l3a <= 49'(p1_sq[43:26]) * 49'(p1_l);
      p2_l3b <= 48'(p1_sq[60:44]) * 48'(p1_l);
      p2_tb  <= p2_tbfull[78:26];
      p2_neg <= p1_neg;
      p2_ok  <= p1_ok;
    end
  end

  // Polynomial stage 3: L3 = L2 * L / 2^26.
  logic [65:0]     p3_full;
  logic [L3_W-1:0] p3_l3;
  logic [TB_W-1:0] p3_tb;
  logic            p3_neg;
  logic            p3_ok;

  assign p3_full = {p2_l3b, 18'b0} + 66'(p2_l3a);

  always_ff @(posedge clk) begin
    if (en) begin
      p3_l3  <= p3_full[65:26];
      p3_tb  <= p2_tb;
      p3_neg <= p2_neg;
      p3_ok  <= p2_ok;
    end
  end

  // Polynomial stage 4: four partial products of coef_c * L3.
  logic [43:0]     p4_c00;
  logic [43:0]     p4_c01;
  logic [43:0]     p4_c10;
  logic [43:0]     p4_c11;
  logic [TB_W-1:0] p4_tb;
  logic            p4_neg;
  logic            p4_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      p4_c00 <= 44'(coef_c[23:0]) * 44'(p3_l3[19:0]);
      p4_c01 <= 44'(coef_c[23:0]) * 44'(p3_l3[39:20]);
      p4_c10 <= 44'(coef_c[47:24]) * 44'(p3_l3[19:0]);
      p4_c11 <= 44'(coef_c[47:24]) * 44'(p3_l3[39:20]);
      p4_tb  <= p3_tb;
      p4_neg <= p3_neg;
      p4_ok  <= p3_ok;
    end
  end

  // Polynomial stage 5: tc = coef_c * L3 / 2^26.
  logic [87:0]     p5_full;
  logic [TC_W-1:0] p5_tc;
  logic [TB_W-1:0] p5_tb;
  logic            p5_neg;
  logic            p5_ok;

  assign p5_full = 88'(p4_c00) + 88'({p4_c01, 20'b0}) + 88'({p4_c10, 24'b0}) +
                   {p4_c11, 44'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      p5_tc  <= p5_full[87:26];
      p5_tb  <= p4_tb;
      p5_neg <= p4_neg;
      p5_ok  <= p4_ok;
    end
  end

  // Polynomial stage 6: denominator D = A +/- (tb + tc).
  logic [SUM_W-1:0] p6_sum;
  logic [D_W-1:0]   p6_add;
  logic [D_W-1:0]   p6_d;
  logic             p6_ok;

  assign p6_sum = SUM_W'(p5_tb) + SUM_W'(p5_tc);
  assign p6_add = D_W'(coef_a) + D_W'(p6_sum);

  always_ff @(posedge clk) begin
    if (en) begin
      if (p5_neg) begin
        p6_d  <= D_W'(coef_a) - D_W'(p6_sum);
        p6_ok <= p5_ok && (D_W'(p6_sum) < D_W'(coef_a));
      end else begin
        p6_d  <= p6_add;
        p6_ok <= p5_ok && (p6_add != '0);
      end
    end
  end

  // Stage 7: rounded dividend N = 100 * 2^frac + D / 2.
  logic [D_W-1:0] p7_n;
  logic [D_W-1:0] p7_d;
  logic           p7_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      p7_n  <= KELVIN_SCALE + {1'b0, p6_d[D_W-1:1]};
      p7_d  <= p6_d;
      p7_ok <= p6_ok;
    end
  end

  // Stage 8 and the Kelvin divider: 16 quotient bits, overflow flagged first.
  logic [D_W-1:0]  kd_rem [0:KD_STEPS];
  logic [KC_W-1:0] kd_low [0:KD_STEPS];
  logic [KC_W-1:0] kd_quo [0:KD_STEPS];
  logic [D_W-1:0]  kd_d   [0:KD_STEPS];
  logic            kd_ovf [0:KD_STEPS];
  logic            kd_ok  [0:KD_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      kd_rem[0] <= {16'b0, p7_n[D_W-1:KC_W]};
      kd_low[0] <= p7_n[KC_W-1:0];
      kd_quo[0] <= '0;
      kd_d[0]   <= p7_d;
      kd_ovf[0] <= {16'b0, p7_n[D_W-1:KC_W]} >= p7_d;
      kd_ok[0]  <= p7_ok;
    end
  end

  for (genvar s = 1; s <= KD_STEPS; s++) begin : g_kdiv
    logic [D_W:0] trial;
    logic         fits;

    assign trial = {kd_rem[s-1], kd_low[s-1][KC_W-1]};
    assign fits  = trial >= {1'b0, kd_d[s-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        kd_rem[s] <= fits ? D_W'(trial - {1'b0, kd_d[s-1]}) : trial[D_W-1:0];
        kd_low[s] <= kd_low[s-1] << 1;
        kd_quo[s] <= {kd_quo[s-1][KC_W-2:0], fits};
        kd_d[s]   <= kd_d[s-1];
        kd_ovf[s] <= kd_ovf[s-1];
        kd_ok[s]  <= kd_ok[s-1];
      end
    end
  end

  // Output register: offset to Celsius with saturation at the top.
  logic [TEMP_W-1:0] out_temp;
  logic              out_res;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!kd_ok[KD_STEPS]) begin
        out_temp <= '0;
        out_res  <= 1'b0;
      end else if (kd_ovf[KD_STEPS] || (kd_quo[KD_STEPS] > KC_MAX)) begin
        out_temp <= TEMP_SAT;
        out_res  <= 1'b1;
      end else begin
        out_temp <= kd_quo[KD_STEPS] - OFFSET_CENTI;
        out_res  <= 1'b1;
      end
    end
  end

  assign out_ch.valid        = vld[DEPTH-1];
  assign out_ch.temp_centi_c = out_temp;
  assign out_ch.valid_res    = out_res;

  // An invalid result always carries a zero temperature.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.valid_res |-> out_ch.temp_centi_c == '0)
    else $error("invalid result with nonzero temperature");

  // A valid result never lies below absolute zero.
  a_above_zero_k: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.valid_res |-> out_ch.temp_centi_c >= -16'sd27315)
    else $error("temperature below absolute zero");

  // The normalizer leaves the leading one at the top for a usable quotient.
  a_norm_top: assert property (@(posedge clk) disable iff (rst)
    vld[ST_NM] && nm_ok[NM_STEPS] |-> nm_q[NM_STEPS][Q_W-1])
    else $error("quotient not normalized");

  // The squaring chain keeps the mantissa in [1, 2).
  a_mant_range: assert property (@(posedge clk) disable iff (rst)
    vld[ST_LG] && lg_ok[F_W] |-> lg_m[F_W][M_W-1])
    else $error("log mantissa out of range");

  // The Kelvin divider ends with a remainder below the divisor.
  a_kdiv_rem: assert property (@(posedge clk) disable iff (rst)
    vld[ST_KD] && kd_ok[KD_STEPS] && !kd_ovf[KD_STEPS] |->
      kd_rem[KD_STEPS] < kd_d[KD_STEPS])
    else $error("Kelvin divider remainder too large");

endmodule
